### rtl/lem_pkg.sv
// Package for the line element mapping block: register indexes, step
// counts, default parameter values. Used by rtl/line_element_mapping.sv.
`timescale 1ns / 1ps
`default_nettype none
package lem_pkg;
  localparam int MAX_DIM_DEF = 3;
  localparam int ONE_Q16 = 65536;
  localparam logic [2:0] REG_DIM = 3'd0;
  localparam logic [2:0] REG_SX  = 3'd1;
  localparam logic [2:0] REG_SY  = 3'd2;
  localparam logic [2:0] REG_SZ  = 3'd3;
  localparam logic [2:0] REG_EX  = 3'd4;
  localparam logic [2:0] REG_EY  = 3'd5;
  localparam logic [2:0] REG_EZ  = 3'd6;
  localparam int ROOT_STEPS = 33;
  localparam int DIV_STEPS = 50;
endpackage
`default_nettype wire

### rtl/line_element_mapping.sv
// Line element mapping: stallable pipeline of interpolation,
// length (digit-serial square root stages) and gradient division stages.
// Depends on lem_pkg.
//
// Usage: write dimension and the two end points through the cfg port while
// idle. Each input beat (in_t_ref, in_grad_ref) yields one output beat with
// the mapped point, length, Jacobian, scaled gradient and degenerate flag.
// One beat enters per cycle while the output is not stalled. The rate is set
// by a pipeline of one root digit per stage (33 stages) and one quotient bit
// per stage (50 stages).
// Reset clears configuration to dimension 1, zero end points, and empties
// the pipeline. A stall on the output freezes all stages together; in_stall
// follows out_stall when the output register holds a beat.
`timescale 1ns / 1ps
`default_nettype none
module line_element_mapping #(
  parameter int MAX_DIM = lem_pkg::MAX_DIM_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [17:0] in_t_ref,
  input  wire logic signed [31:0] in_grad_ref,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_phys_x,
  output logic signed [31:0]      out_phys_y,
  output logic signed [31:0]      out_phys_z,
  output logic signed [31:0]      out_grad_phys,
  output logic [33:0]             out_jacobian,
  output logic [34:0]             out_elem_length,
  output logic                    out_degenerate
);
  localparam int RS = lem_pkg::ROOT_STEPS;
  localparam int DS = lem_pkg::DIV_STEPS;
  localparam int NST = 3 + RS + DS;

  logic [1:0] dim_r;
  logic signed [31:0] s_r [3];
  logic signed [31:0] e_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= 2'd1;
      for (int i = 0; i < 3; i++) begin
        s_r[i] <= '0;
        e_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        lem_pkg::REG_DIM: dim_r <= cfg_data[1:0];
        lem_pkg::REG_SX: s_r[0] <= cfg_data;
        lem_pkg::REG_SY: s_r[1] <= cfg_data;
        lem_pkg::REG_SZ: s_r[2] <= cfg_data;
        lem_pkg::REG_EX: e_r[0] <= cfg_data;
        lem_pkg::REG_EY: e_r[1] <= cfg_data;
        lem_pkg::REG_EZ: e_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic [NST-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NST-2:0], in_valid};
  end
  assign out_valid = v_r[NST-1];

  // effective dimension
  logic [1:0] dim_eff;
  always_comb begin
    dim_eff = dim_r;
    if (dim_eff == 2'd0) dim_eff = 2'd1;
    if (32'(dim_eff) > MAX_DIM) dim_eff = 2'(MAX_DIM);
  end

  // stage 1: clamp t, differences, products
  logic signed [17:0] t_c;
  always_comb begin
    t_c = in_t_ref;
    if (in_t_ref > 18'sd65536) t_c = 18'sd65536;
    if (in_t_ref < -18'sd65536) t_c = -18'sd65536;
  end

  logic signed [49:0] ps1_r [3];
  logic signed [49:0] pe1_r [3];
  logic [32:0] mag1_r [3];
  logic signed [31:0] g1_r;
  logic [2:0] use1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ps1_r[i] <= 50'(s_r[i] * (19'sd65536 - 19'(t_c)));
        pe1_r[i] <= 50'(e_r[i] * (19'sd65536 + 19'(t_c)));
        if (e_r[i] >= s_r[i]) mag1_r[i] <= 33'(e_r[i]) - 33'(s_r[i]);
        else mag1_r[i] <= 33'(s_r[i]) - 33'(e_r[i]);
        use1_r[i] <= (2'(i) < dim_eff);
      end
      g1_r <= in_grad_ref;
    end
  end

  // stage 2: phys rounding, squares
  logic signed [31:0] ph2_r [3];
  logic [65:0] sq2_r [3];
  logic signed [31:0] g2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [51:0] sv;
        sv = 52'(ps1_r[i]) + 52'(pe1_r[i]) + 52'sd65536;
        ph2_r[i] <= use1_r[i] ? sv[48:17] : '0;
        sq2_r[i] <= use1_r[i] ? 66'(mag1_r[i]) * 66'(mag1_r[i]) : '0;
      end
      g2_r <= g1_r;
    end
  end

  // stage 3: sum of squares
  logic [67:0] sum3_r;
  logic signed [31:0] ph3_r [3];
  logic signed [31:0] g3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sum3_r <= 68'(sq2_r[0]) + 68'(sq2_r[1]) + 68'(sq2_r[2]);
      ph3_r <= ph2_r;
      g3_r <= g2_r;
    end
  end

  // root stages, one digit each
  logic [67:0] rr_rad_r [RS+1];
  logic [35:0] rr_rem_r [RS+1];
  logic [33:0] rr_root_r [RS+1];
  logic signed [31:0] rr_g_r [RS+1];
  logic signed [31:0] rr_ph_r [RS+1][3];
  always_comb begin
    rr_rad_r[0] = sum3_r;
    rr_rem_r[0] = '0;
    rr_root_r[0] = '0;
    rr_g_r[0] = g3_r;
    rr_ph_r[0] = ph3_r;
  end
  for (genvar k = 0; k < RS; k++) begin : g_root
    logic [35:0] rem_n;
    logic [35:0] trial;
    always_comb begin
      rem_n = {rr_rem_r[k][33:0], rr_rad_r[k][2*(RS-1-k)+1 -: 2]};
      trial = {rr_root_r[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rr_rad_r[k+1] <= rr_rad_r[k];
        rr_g_r[k+1] <= rr_g_r[k];
        rr_ph_r[k+1] <= rr_ph_r[k];
        if (rem_n >= trial) begin
          rr_rem_r[k+1] <= rem_n - trial;
          rr_root_r[k+1] <= {rr_root_r[k][32:0], 1'b1};
        end else begin
          rr_rem_r[k+1] <= rem_n;
          rr_root_r[k+1] <= {rr_root_r[k][32:0], 1'b0};
        end
      end
    end
  end

  logic [34:0] len_a;
  logic deg_a;
  always_comb begin
    len_a = 35'(rr_root_r[RS]);
    if (36'(rr_rem_r[RS]) > 36'(rr_root_r[RS])) len_a = len_a + 35'd1;
    deg_a = (rr_rad_r[RS] == '0);
  end

  // divide stages: quotient of (|g|<<17 + len/2) by len, one bit each
  logic [49:0] dv_num_r [DS+1];
  logic [35:0] dv_rem_r [DS+1];
  logic [49:0] dv_q_r [DS+1];
  logic [34:0] dv_len_r [DS+1];
  logic dv_neg_r [DS+1];
  logic dv_deg_r [DS+1];
  logic signed [31:0] dv_ph_r [DS+1][3];
  always_comb begin
    logic [31:0] ag;
    ag = rr_g_r[RS][31] ? 32'(-33'(rr_g_r[RS])) : 32'(rr_g_r[RS]);
    dv_num_r[0] = {1'b0, ag, 17'd0} + 50'(len_a[34:1]);
    dv_rem_r[0] = '0;
    dv_q_r[0] = '0;
    dv_len_r[0] = deg_a ? 35'd1 : len_a;
    dv_neg_r[0] = rr_g_r[RS][31];
    dv_deg_r[0] = deg_a;
    dv_ph_r[0] = rr_ph_r[RS];
  end
  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [35:0] rem_n;
    assign rem_n = {dv_rem_r[k][34:0], dv_num_r[k][DS-1-k]};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_num_r[k+1] <= dv_num_r[k];
        dv_len_r[k+1] <= dv_len_r[k];
        dv_neg_r[k+1] <= dv_neg_r[k];
        dv_deg_r[k+1] <= dv_deg_r[k];
        dv_ph_r[k+1] <= dv_ph_r[k];
        if (rem_n >= 36'(dv_len_r[k])) begin
          dv_rem_r[k+1] <= rem_n - 36'(dv_len_r[k]);
          dv_q_r[k+1] <= {dv_q_r[k][48:0], 1'b1};
        end else begin
          dv_rem_r[k+1] <= rem_n;
          dv_q_r[k+1] <= {dv_q_r[k][48:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    logic [49:0] q;
    q = dv_q_r[DS];
    out_phys_x = dv_ph_r[DS][0];
    out_phys_y = dv_ph_r[DS][1];
    out_phys_z = dv_ph_r[DS][2];
    out_degenerate = dv_deg_r[DS];
    if (dv_deg_r[DS]) begin
      out_grad_phys = '0;
      out_elem_length = '0;
      out_jacobian = '0;
    end else begin
      out_elem_length = dv_len_r[DS];
      out_jacobian = 34'((36'(dv_len_r[DS]) + 36'd1) >> 1);
      if (dv_neg_r[DS]) begin
        if (q > 50'h80000000) q = 50'h80000000;
        out_grad_phys = 32'(-q);
      end else begin
        if (q > 50'h7FFFFFFF) q = 50'h7FFFFFFF;
        out_grad_phys = q[31:0];
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_grad_phys))
    else $error("output beat changed under stall");
  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_elem_length == '0 && out_grad_phys == '0)
    else $error("degenerate beat with nonzero length");
  a_jac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 35'(out_jacobian) <= out_elem_length)
    else $error("jacobian above length");
endmodule
`default_nettype wire
